### rtl/lfr_pkg.sv
// Shared constants and types for the LRU frame replacer.
package lfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int CNT_W      = 7;
  localparam int FRAME_W    = 6;
  localparam int ACT_W      = 2;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_VICTIM = 2'd0;
  localparam action_t ACT_PIN    = 2'd1;
  localparam action_t ACT_UNPIN  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_VREAD = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

### rtl/lfr_ram.sv
// Generic simple dual-port RAM with registered read.
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/lru_frame_replacer_top.sv
// Top level of the LRU frame replacer: control, membership flags and recency RAM.
// Sequence: unpin, ignored pin, victim on an empty set and no-op go straight to S_DONE;
//   victim reads the head in S_VREAD first, pin of a tracked frame walks the ring in S_SCAN.
// Flow: one word in flight; the next word is taken only once S_DONE has posted the last
//   result and the block is back in S_IDLE. A result still waiting in the output register
//   does not hold off the next word.
// Reset (rst_n, synchronous): clears membership flags, count, head and capacity (64);
//   recency RAM contents stay undefined, only entries below the count are ever used.
module lru_frame_replacer_top
  import lfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FRAME_W-1:0] in_frame_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_victim_found,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic [CNT_W-1:0]   out_tracked_count
);

  // Control state
  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;       // ring position of least recent frame
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NUM_FRAMES-1:0] present_r, present_nxt;
  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;             // next ring offset to read in a pin scan
  logic                  rvalid_r, rvalid_nxt;   // RAM data for offset rpos_r arrives now
  logic [CNT_W-1:0]      rpos_r, rpos_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload registers
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [FRAME_W-1:0]    res_frame_r, res_frame_nxt;
  logic                  o_found_r, o_found_nxt;
  logic [FRAME_W-1:0]    o_frame_r, o_frame_nxt;
  logic [CNT_W-1:0]      o_count_r, o_count_nxt;

  // RAM port
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [IDX_W-1:0]      ram_rdata;

  logic                  frame_ok;
  logic [IDX_W-1:0]      in_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_idx   = in_frame_id[IDX_W-1:0];
  assign frame_ok = (int'(in_frame_id) < NUM_FRAMES);

  lfr_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_FRAMES)
  ) u_recency_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    present_nxt   = present_r;
    cap_nxt       = cap_r;
    k_nxt         = k_r;
    rvalid_nxt    = 1'b0;
    rpos_nxt      = rpos_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    frame_nxt     = frame_r;
    res_found_nxt = res_found_r;
    res_frame_nxt = res_frame_r;
    o_found_nxt   = o_found_r;
    o_frame_nxt   = o_frame_r;
    o_count_nxt   = o_count_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = head_r;

    // The user must let configuration land only while idle; the block does not enforce it and takes it as it comes.
    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
    end

    // Drop the output word once it is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          frame_nxt     = in_frame_id;
          res_found_nxt = 1'b0;
          res_frame_nxt = '0;
          priority if (in_action == ACT_VICTIM && count_r != '0) begin
            // Fetch the oldest entry at the head of the ring.
            ram_raddr = head_r;
            state_nxt = S_VREAD;
          end else if (in_action == ACT_PIN && frame_ok && present_r[in_idx]) begin
            present_nxt[in_idx] = 1'b0;
            k_nxt               = '0;
            found_nxt           = 1'b0;
            state_nxt           = S_SCAN;
          end else if (in_action == ACT_UNPIN && frame_ok && !present_r[in_idx] &&
                       count_r < cap_r && int'(count_r) < NUM_FRAMES) begin
            // Append as most recent at the tail of the ring.
            ram_we              = 1'b1;
            ram_waddr           = head_r + count_r[IDX_W-1:0];
            ram_wdata           = in_idx;
            count_nxt           = count_r + CNT_W'(1);
            present_nxt[in_idx] = 1'b1;
            state_nxt           = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_VREAD: begin
        res_found_nxt          = 1'b1;
        res_frame_nxt          = FRAME_W'(ram_rdata);
        present_nxt[ram_rdata] = 1'b0;
        head_nxt               = head_r + IDX_W'(1);
        count_nxt              = count_r - CNT_W'(1);
        state_nxt              = S_DONE;
      end

      S_SCAN: begin
        // Walk the ring: read one offset a cycle, and once the pinned frame is
        // behind us, move each later entry down one slot.
        ram_raddr = head_r + k_r[IDX_W-1:0];
        if (k_r < count_r) begin
          rvalid_nxt = 1'b1;
          rpos_nxt   = k_r;
          k_nxt      = k_r + CNT_W'(1);
        end
        if (rvalid_r) begin
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = head_r + rpos_r[IDX_W-1:0] - IDX_W'(1);
            ram_wdata = ram_rdata;
          end else if (ram_rdata == frame_r[IDX_W-1:0]) begin
            found_nxt = 1'b1;
          end
          if (rpos_r == count_r - CNT_W'(1)) begin
            count_nxt  = count_r - CNT_W'(1);
            rvalid_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free, then post the word.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = res_found_r;
          o_frame_nxt   = res_frame_r;
          o_count_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      present_r   <= '0;
      cap_r       <= CNT_W'(64);
      k_r         <= '0;
      rvalid_r    <= 1'b0;
      rpos_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      cap_r       <= cap_nxt;
      k_r         <= k_nxt;
      rvalid_r    <= rvalid_nxt;
      rpos_r      <= rpos_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r     <= frame_nxt;
    res_found_r <= res_found_nxt;
    res_frame_r <= res_frame_nxt;
    o_found_r   <= o_found_nxt;
    o_frame_r   <= o_frame_nxt;
    o_count_r   <= o_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_victim_found  = o_found_r;
  assign out_victim_frame  = o_frame_r;
  assign out_tracked_count = o_count_r;

  // Membership flags and list length agree whenever no operation is in flight.
  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(present_r) == int'(count_r)))
    else $error("tracked count disagrees with membership flags");

  // The count never exceeds the number of frames.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= NUM_FRAMES)
    else $error("tracked count out of range");

  // A scan only sees data for offsets inside the list.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rvalid_r) |-> (rpos_r < count_r))
    else $error("pin scan read beyond the list");

  // An accepted unpin that is taken grows the count by one.
  a_unpin_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_UNPIN && frame_ok &&
     !present_r[in_idx] && count_r < cap_r && int'(count_r) < NUM_FRAMES)
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("unpin did not append");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the LRU frame replacer: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb_top;
  import lfr_pkg::*;

  // Action code 3 is unused by the block; it must act as a no-op.
  localparam action_t ACT_NOP = 2'd3;

  localparam int RESET_CYCLES    = 11;
  localparam int MAX_CAP         = 64;
  localparam int CAP_RANDOM      = -1;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 195;
  // Worst case is a pin of a tracked frame (one pass over the ring) plus the
  // longest sender gap and receiver stall; take that many times over.
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = NUM_FRAMES + 8;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
  } lru_result_t;

  typedef struct packed {
    action_t            act;
    logic [FRAME_W-1:0] frame;
    logic               typed;
    lru_result_t        want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  action_t            in_action   = ACT_VICTIM;
  logic [FRAME_W-1:0] in_frame_id = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               out_victim_found;
  logic [FRAME_W-1:0] out_victim_frame;
  logic [CNT_W-1:0]   out_tracked_count;

  always #6 clk = ~clk;

  lru_frame_replacer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_frame_id       (in_frame_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_victim_found  (out_victim_found),
    .out_victim_frame  (out_victim_frame),
    .out_tracked_count (out_tracked_count)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: membership flags, recency order (front is oldest) and
  // the capacity register as last written.
  // ---------------------------------------------------------------------------
  bit                 tracked_flag [NUM_FRAMES];
  logic [FRAME_W-1:0] lru_order [$];
  logic [CNT_W-1:0]   cap_model = CNT_W'(MAX_CAP);

  // Results of accepted words, oldest first, waiting for the output side.
  lru_result_t        pending_results [$];

  int                 err_count = 0;
  bit                 quiet     = 1'b0;   // when set, neither side idles

  // Apply one word to the predictor and return the result it must produce.
  function automatic lru_result_t replacer_step(action_t act, logic [FRAME_W-1:0] fr);
    lru_result_t res;
    res = '0;
    case (act)
      ACT_VICTIM: begin
        // Evict the oldest entry; an empty set leaves everything alone.
        if (lru_order.size() > 0) begin
          res.frame = lru_order.pop_front();
          res.found = 1'b1;
          tracked_flag[res.frame] = 1'b0;
        end
      end
      ACT_PIN: begin
        if (tracked_flag[fr]) begin
          for (int k = 0; k < lru_order.size(); k++) begin
            if (lru_order[k] == fr) begin
              lru_order.delete(k);
              break;
            end
          end
          tracked_flag[fr] = 1'b0;
        end
      end
      ACT_UNPIN: begin
        // Drop duplicates without refreshing recency, and drop when full.
        if (!tracked_flag[fr] && lru_order.size() < int'(cap_model) &&
            lru_order.size() < NUM_FRAMES) begin
          lru_order.push_back(fr);
          tracked_flag[fr] = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(lru_order.size());
    return res;
  endfunction

  // Pick a frame that is likely to matter: tracked, untracked, an extreme,
  // or plain random.
  function automatic logic [FRAME_W-1:0] choose_frame();
    int r;
    int start;
    r = $urandom_range(0, 99);
    if (r < 35 && lru_order.size() > 0)
      return lru_order[$urandom_range(0, lru_order.size() - 1)];
    if (r < 70 && lru_order.size() < NUM_FRAMES) begin
      start = $urandom_range(0, NUM_FRAMES - 1);
      for (int k = 0; k < NUM_FRAMES; k++)
        if (!tracked_flag[(start + k) % NUM_FRAMES])
          return FRAME_W'((start + k) % NUM_FRAMES);
    end
    if (r < 80)
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Present one word, hold it until accepted, then queue its expected result.
  // A typed row supplies its own result; the predictor still steps.
  task automatic send_word(input action_t act, input logic [FRAME_W-1:0] fr,
                           input logic typed, input lru_result_t want);
    int          gap;
    lru_result_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_frame_id <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = replacer_step(act, fr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Write capacity only once the block has handed back every result.
  task automatic set_capacity(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_model = value;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run with the reset capacity of 64. Typed rows hold results
  // that follow straight from the ordering; the rest go to the predictor.
  // ---------------------------------------------------------------------------
  localparam int DIR_ROWS = 19;
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ACT_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},  // victim on empty set
    '{ACT_NOP,    6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},  // unused action code
    '{ACT_PIN,    6'd5,  1'b1, '{1'b0, 6'd0,  7'd0}},  // pin of untracked frame
    '{ACT_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd1}},
    '{ACT_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},
    '{ACT_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd2}},  // duplicate, no refresh
    '{ACT_UNPIN,  6'd42, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_UNPIN,  6'd21, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_PIN,    6'd63, 1'b0, '{1'b0, 6'd0,  7'd0}},  // remove from the middle
    '{ACT_UNPIN,  6'd63, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_VICTIM, 6'd63, 1'b1, '{1'b1, 6'd0,  7'd3}},  // oldest is frame 0
    '{ACT_VICTIM, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_PIN,    6'd21, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_NOP,    6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{ACT_VICTIM, 6'd0,  1'b1, '{1'b1, 6'd63, 7'd0}},
    '{ACT_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ACT_PIN,    6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ACT_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd1}},
    '{ACT_PIN,    6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}}   // pin of the only entry
  };

  // Random phases: capacity and operation mix per phase. The state carries
  // over, so lowering capacity finds the set above the new limit.
  int phase_cap   [PHASES] = '{64, 5, 0, 1, 64, 63, CAP_RANDOM, 2, 64};
  int phase_unpin [PHASES] = '{70, 40, 40, 45, 45, 70, 50, 45, 20};
  int phase_pin   [PHASES] = '{15, 30, 20, 20, 25, 10, 20, 20, 20};

  // ---------------------------------------------------------------------------
  // Result side: check each accepted word against the oldest expectation,
  // then decide whether to stall the next cycle.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : result_sink
    lru_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", 32'(out_tracked_count), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_victim_found !== want.found)
            report_mismatch("victim_found", 32'(out_victim_found), 32'(want.found));
          if (out_victim_frame !== want.frame)
            report_mismatch("victim_frame", 32'(out_victim_frame), 32'(want.frame));
          if (out_tracked_count !== want.count)
            report_mismatch("tracked_count", 32'(out_tracked_count), 32'(want.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 99) < 80) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_ready  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no word moves on either side for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                 r;
    int                 cap;
    action_t            act;
    logic [FRAME_W-1:0] fr;

    // Hold reset, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i])
      send_word(dir_table[i].act, dir_table[i].frame, dir_table[i].typed, dir_table[i].want);

    for (int p = 0; p < PHASES; p++) begin
      cap = (phase_cap[p] == CAP_RANDOM) ? $urandom_range(0, MAX_CAP) : phase_cap[p];
      set_capacity(CNT_W'(cap));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then run a stretch with no idling on either side.
        if (n % 64 == 0)
          quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < phase_unpin[p])
          act = ACT_UNPIN;
        else if (r < phase_unpin[p] + phase_pin[p])
          act = ACT_PIN;
        else if (r < 97)
          act = ACT_VICTIM;
        else
          act = ACT_NOP;
        fr = (act == ACT_VICTIM || act == ACT_NOP) ?
             FRAME_W'($urandom_range(0, NUM_FRAMES - 1)) : choose_frame();
        send_word(act, fr, 1'b0, '0);
      end
    end

    // Drain: wait for every result, then watch a while for stray words.
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### lru_frame_replacer_top.f
rtl/lfr_pkg.sv
rtl/lfr_ram.sv
rtl/lru_frame_replacer_top.sv
tb/sv/tb_top.sv
